// ----- design/rmfh_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rmfh_pkg
// Types, codes and sizes shared by the recursive mutex with FIFO hand-off.
// ----------------------------------------------------------------------------
package rmfh_pkg;

    localparam int QUEUE_DEPTH  = 16;
    localparam int TASK_ID_BITS = 8;
    localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [QPTR_W-1:0] QPTR_LAST  = QPTR_W'(QUEUE_DEPTH - 1);
    localparam logic [QCNT_W-1:0] QCNT_FULL  = QCNT_W'(QUEUE_DEPTH);
    localparam logic [7:0]        TASK_MASK  = 8'((1 << TASK_ID_BITS) - 1);
    localparam logic [7:0]        COUNT_MAX  = 8'd255;

    typedef enum logic [2:0] {
        ST_ACQUIRED   = 3'd0,
        ST_RECURSIVE  = 3'd1,
        ST_QUEUED     = 3'd2,
        ST_NOT_OWNER  = 3'd3,
        ST_STILL_HELD = 3'd4,
        ST_FREED      = 3'd5,
        ST_HANDED     = 3'd6,
        ST_OVERFLOW   = 3'd7
    } status_t;

    typedef enum logic {
        OP_LOCK   = 1'b0,
        OP_UNLOCK = 1'b1
    } op_t;

    typedef struct packed {
        logic       operation;
        logic [7:0] task_id;
        logic [2:0] task_core;
        logic [2:0] requester_core;
    } in_item_t;

    typedef struct packed {
        status_t    status;
        logic       lock_held;
        logic [7:0] owner_id;
        logic [7:0] hold_count;
        logic       wake_valid;
        logic [2:0] wake_core;
        logic       wake_local;
    } out_item_t;

    // one waiter in the queue memory
    typedef struct packed {
        logic [7:0] task_id;
        logic [2:0] core;
    } waiter_t;

    typedef struct packed {
        logic capture;
        logic commit;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_stat_t;

    function automatic logic [QPTR_W-1:0] next_slot(input logic [QPTR_W-1:0] p);
        logic [QPTR_W-1:0] n;
        if (p == QPTR_LAST) begin
            n = '0;
        end else begin
            n = p + QPTR_W'(1);
        end
        return n;
    endfunction

endpackage : rmfh_pkg
`default_nettype wire

// ----- design/rmfh_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rmfh_ctrl
// Two-state sequencer: capture a request, then commit it once the output
// register can take the result.
// ----------------------------------------------------------------------------
module rmfh_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire rmfh_pkg::dp_stat_t dp_stat,
    output rmfh_pkg::dp_cmd_t      dp_cmd
);
    import rmfh_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next     = state_reg;
        dp_cmd.capture = 1'b0;
        dp_cmd.commit  = 1'b0;
        s_ready        = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    dp_cmd.capture = 1'b1;
                    state_next     = S_EXEC;
                end
            end
            S_EXEC: begin
                if (dp_stat.out_free) begin
                    dp_cmd.commit = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule : rmfh_ctrl
`default_nettype wire

// ----- design/rmfh_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rmfh_dp
// Lock state, waiter queue memory, decision logic and output register.
// ----------------------------------------------------------------------------
module rmfh_dp (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire rmfh_pkg::in_item_t s_payload,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output rmfh_pkg::out_item_t    m_payload,
    input  wire rmfh_pkg::dp_cmd_t dp_cmd,
    output rmfh_pkg::dp_stat_t     dp_stat
);
    import rmfh_pkg::*;

    waiter_t mem [QUEUE_DEPTH];

    in_item_t          in_reg;
    waiter_t           head_reg;
    out_item_t         out_reg, out_next;
    logic              out_valid_reg;

    logic              owner_valid_reg, owner_valid_next;
    logic [7:0]        owner_task_reg, owner_task_next;
    logic [7:0]        count_reg, count_next;
    logic [QPTR_W-1:0] qhead_reg, qhead_next;
    logic [QPTR_W-1:0] qtail_reg, qtail_next;
    logic [QCNT_W-1:0] qcount_reg, qcount_next;
    logic              push;

    logic [7:0]        tid;
    status_t           status;
    logic              wake_valid;
    logic [2:0]        wake_core;
    logic              wake_local;

    assign tid              = in_reg.task_id & TASK_MASK;
    assign dp_stat.out_free = !out_valid_reg || m_ready;
    assign m_valid          = out_valid_reg;
    assign m_payload        = out_reg;

    always_comb begin
        owner_valid_next = owner_valid_reg;
        owner_task_next  = owner_task_reg;
        count_next       = count_reg;
        qhead_next       = qhead_reg;
        qtail_next       = qtail_reg;
        qcount_next      = qcount_reg;
        push             = 1'b0;
        wake_valid       = 1'b0;
        wake_core        = '0;
        wake_local       = 1'b0;
        status           = ST_NOT_OWNER;
        if (in_reg.operation == OP_LOCK) begin
            priority if (!owner_valid_reg) begin
                owner_valid_next = 1'b1;
                owner_task_next  = tid;
                count_next       = 8'd1;
                status           = ST_ACQUIRED;
            end else if (owner_task_reg == tid) begin
                if (count_reg >= COUNT_MAX) begin
                    status = ST_OVERFLOW;
                end else begin
                    count_next = count_reg + 8'd1;
                    status     = ST_RECURSIVE;
                end
            end else if (qcount_reg >= QCNT_FULL) begin
                status = ST_OVERFLOW;
            end else begin
                push        = 1'b1;
                qtail_next  = next_slot(qtail_reg);
                qcount_next = qcount_reg + QCNT_W'(1);
                status      = ST_QUEUED;
            end
        end else begin
            priority if (!owner_valid_reg || owner_task_reg != tid) begin
                status = ST_NOT_OWNER;
            end else if (count_reg > 8'd1) begin
                count_next = count_reg - 8'd1;
                status     = ST_STILL_HELD;
            end else if (qcount_reg == '0) begin
                owner_valid_next = 1'b0;
                owner_task_next  = '0;
                count_next       = '0;
                status           = ST_FREED;
            end else begin
                // hand the lock to the oldest waiter
                owner_task_next = head_reg.task_id;
                wake_core       = head_reg.core;
                qhead_next      = next_slot(qhead_reg);
                qcount_next     = qcount_reg - QCNT_W'(1);
                count_next      = 8'd1;
                wake_valid      = 1'b1;
                wake_local      = (head_reg.core == in_reg.requester_core);
                status          = ST_HANDED;
            end
        end

        out_next.status     = status;
        out_next.lock_held  = owner_valid_next;
        out_next.owner_id   = owner_valid_next ? owner_task_next : 8'd0;
        out_next.hold_count = owner_valid_next ? count_next : 8'd0;
        out_next.wake_valid = wake_valid;
        out_next.wake_core  = wake_core;
        out_next.wake_local = wake_local;
    end

    // queue memory: read head on capture, write tail on commit
    always_ff @(posedge aclk) begin
        if (dp_cmd.capture) begin
            head_reg <= mem[qhead_reg];
        end
        if (dp_cmd.commit && push) begin
            mem[qtail_reg] <= '{task_id: tid, core: in_reg.task_core};
        end
    end

    always_ff @(posedge aclk) begin
        if (dp_cmd.capture) begin
            in_reg <= s_payload;
        end
        if (dp_cmd.commit) begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            owner_valid_reg <= 1'b0;
            owner_task_reg  <= '0;
            count_reg       <= '0;
            qhead_reg       <= '0;
            qtail_reg       <= '0;
            qcount_reg      <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (dp_cmd.commit) begin
                owner_valid_reg <= owner_valid_next;
                owner_task_reg  <= owner_task_next;
                count_reg       <= count_next;
                qhead_reg       <= qhead_next;
                qtail_reg       <= qtail_next;
                qcount_reg      <= qcount_next;
                out_valid_reg   <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule : rmfh_dp
`default_nettype wire

// ----- design/recursive_mutex_fifo_handoff.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// recursive_mutex_fifo_handoff
// Recursive hardware lock with a FIFO wait queue and hand-off on release.
//
//   channel  ports                        carries
//   s_       s_valid s_ready s_payload    lock / unlock request
//   m_       m_valid m_ready m_payload    one result per request
//
// A request is first captured and the queue head read from the waiter
// memory; then the block decides and updates the lock state.
// The result sits in an output register; the next request is captured
// while it waits, and its commit waits until that register is taken.
// Synchronous active-low reset clears the lock and queue pointers; the
// waiter memory needs no clearing pass.
// ----------------------------------------------------------------------------
module recursive_mutex_fifo_handoff (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire rmfh_pkg::in_item_t s_payload,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output rmfh_pkg::out_item_t    m_payload
);
    import rmfh_pkg::*;

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    rmfh_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .dp_stat (dp_stat),
        .dp_cmd  (dp_cmd)
    );

    rmfh_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .dp_cmd    (dp_cmd),
        .dp_stat   (dp_stat)
    );

endmodule : recursive_mutex_fifo_handoff
`default_nettype wire

// ----- tb/sv/recursive_mutex_fifo_handoff_test.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// recursive_mutex_fifo_handoff_test
// Self-checking bench for the recursive lock with FIFO hand-off. A planner
// builds lock and unlock sequences against its own copy of the lock state.
// The driver offers them in random bursts. The monitor checks every result
// against a lock predictor that is stepped on each accepted request.
// ----------------------------------------------------------------------------
module recursive_mutex_fifo_handoff_test;
    import rmfh_pkg::*;

    typedef struct {
        logic              owner_valid;
        logic [7:0]        owner_task;
        logic [7:0]        count;
        logic [7:0]        wtask [QUEUE_DEPTH];
        logic [2:0]        wcore [QUEUE_DEPTH];
        logic [QPTR_W-1:0] head;
        logic [QPTR_W-1:0] tail;
        logic [QCNT_W-1:0] qcount;
    } lock_state_t;

    logic      aclk      = 1'b0;
    logic      aresetn   = 1'b0;
    logic      s_valid   = 1'b0;
    logic      m_ready   = 1'b0;
    in_item_t  s_payload = '0;
    logic      s_ready;
    logic      m_valid;
    out_item_t m_payload;

    in_item_t    pending_reqs[$];
    out_item_t   expected_results[$];
    lock_state_t plan_lock;
    lock_state_t model_lock;

    int n_items    = 0;
    int n_accepted = 0;
    int n_results  = 0;
    int fail_count = 0;
    bit req_taken  = 1'b0;

    int burst_left = 4;
    int gap_left   = 0;
    int hold_left  = 0;
    bit hold_done  = 1'b0;
    int rx_mode    = 0;
    int mode_left  = 0;
    int pat_cnt    = 0;

    recursive_mutex_fifo_handoff dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic void lock_clear(output lock_state_t st);
        st.owner_valid = 1'b0;
        st.owner_task  = '0;
        st.count       = '0;
        st.head        = '0;
        st.tail        = '0;
        st.qcount      = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            st.wtask[i] = '0;
            st.wcore[i] = '0;
        end
    endfunction

    function automatic logic [QPTR_W-1:0] slot_after(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    // one request against the lock state, returns the result it produces
    function automatic out_item_t lock_predict(inout lock_state_t st, input in_item_t req);
        out_item_t  r;
        logic [7:0] tid;
        tid = req.task_id & TASK_MASK;
        r = '0;
        if (req.operation == OP_LOCK) begin
            if (!st.owner_valid) begin
                st.owner_valid = 1'b1;
                st.owner_task  = tid;
                st.count       = 8'd1;
                r.status       = ST_ACQUIRED;
            end else if (st.owner_task == tid) begin
                if (st.count >= COUNT_MAX) begin
                    r.status = ST_OVERFLOW;
                end else begin
                    st.count = st.count + 8'd1;
                    r.status = ST_RECURSIVE;
                end
            end else if (st.qcount >= QCNT_FULL) begin
                r.status = ST_OVERFLOW;
            end else begin
                st.wtask[st.tail] = tid;
                st.wcore[st.tail] = req.task_core;
                st.tail   = slot_after(st.tail);
                st.qcount = st.qcount + QCNT_W'(1);
                r.status  = ST_QUEUED;
            end
        end else begin
            if (!st.owner_valid || st.owner_task != tid) begin
                r.status = ST_NOT_OWNER;
            end else if (st.count > 8'd1) begin
                st.count = st.count - 8'd1;
                r.status = ST_STILL_HELD;
            end else if (st.qcount == '0) begin
                st.owner_valid = 1'b0;
                st.owner_task  = '0;
                st.count       = '0;
                r.status       = ST_FREED;
            end else begin
                st.owner_task = st.wtask[st.head];
                r.wake_core   = st.wcore[st.head];
                st.head       = slot_after(st.head);
                st.qcount     = st.qcount - QCNT_W'(1);
                st.count      = 8'd1;
                r.wake_valid  = 1'b1;
                r.wake_local  = (r.wake_core == req.requester_core);
                r.status      = ST_HANDED;
            end
        end
        r.lock_held  = st.owner_valid;
        r.owner_id   = st.owner_valid ? st.owner_task : 8'd0;
        r.hold_count = st.owner_valid ? st.count : 8'd0;
        return r;
    endfunction

    task automatic report(input string msg);
        if (fail_count < 40) begin
            $display("ERROR: %s", msg);
        end
        fail_count++;
    endtask

    // ---- request planning --------------------------------------------------

    function automatic logic [7:0] pick_task();
        logic [7:0] pool [4] = '{8'h01, 8'h02, 8'h03, 8'h80};
        if ($urandom_range(0, 1) == 0) begin
            return pool[$urandom_range(0, 3)];
        end
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] other_task(input logic [7:0] owner);
        logic [7:0] t;
        t = pick_task();
        while (t == owner) begin
            t = 8'($urandom_range(0, 255));
        end
        return t;
    endfunction

    // requester core for an unlock: often the head waiter's core, so both
    // local and remote wakeups show up
    function automatic logic [2:0] unlock_core();
        if (plan_lock.qcount != '0 && $urandom_range(0, 1) == 0) begin
            return plan_lock.wcore[plan_lock.head];
        end
        return 3'($urandom_range(0, 7));
    endfunction

    task automatic plan(input op_t op, input logic [7:0] tid,
                        input logic [2:0] tcore, input logic [2:0] rcore);
        in_item_t  it;
        it.operation      = op;
        it.task_id        = tid;
        it.task_core      = tcore;
        it.requester_core = rcore;
        pending_reqs.push_back(it);
        void'(lock_predict(plan_lock, it));
    endtask

    task automatic ensure_held();
        if (!plan_lock.owner_valid) begin
            plan(OP_LOCK, pick_task(), 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
        end
    endtask

    task automatic release_all();
        while (plan_lock.owner_valid) begin
            plan(OP_UNLOCK, plan_lock.owner_task, 3'($urandom_range(0, 7)), unlock_core());
        end
    endtask

    // ---- driver ------------------------------------------------------------

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            expected_results.push_back(lock_predict(model_lock, s_payload));
            n_accepted++;
            req_taken = 1'b1;
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || req_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                s_payload <= pending_reqs.pop_front();
                s_valid   <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
        req_taken = 1'b0;
    end

    // ---- receiver ----------------------------------------------------------

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (!hold_done && n_accepted >= 150) begin
            // long back-pressure so the block fills and stalls its input
            hold_done = 1'b1;
            hold_left = 400;
            m_ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode   = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            pat_cnt++;
            case (rx_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= ($urandom_range(0, 3) != 0);
                2: m_ready <= ($urandom_range(0, 3) == 0);
                default: m_ready <= (pat_cnt % 5 != 0);
            endcase
        end
    end

    // ---- monitor -----------------------------------------------------------

    always @(posedge aclk) begin
        out_item_t got;
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            got = m_payload;
            if (expected_results.size() == 0) begin
                report($sformatf("result %0d with no request outstanding: %h", n_results, got));
            end else begin
                want = expected_results.pop_front();
                if (got.status !== want.status)
                    report($sformatf("result %0d status got %0d want %0d",
                                     n_results, got.status, want.status));
                if (got.lock_held !== want.lock_held)
                    report($sformatf("result %0d lock_held got %0b want %0b",
                                     n_results, got.lock_held, want.lock_held));
                if (got.owner_id !== want.owner_id)
                    report($sformatf("result %0d owner_id got %0h want %0h",
                                     n_results, got.owner_id, want.owner_id));
                if (got.hold_count !== want.hold_count)
                    report($sformatf("result %0d hold_count got %0d want %0d",
                                     n_results, got.hold_count, want.hold_count));
                if (got.wake_valid !== want.wake_valid)
                    report($sformatf("result %0d wake_valid got %0b want %0b",
                                     n_results, got.wake_valid, want.wake_valid));
                if (got.wake_core !== want.wake_core)
                    report($sformatf("result %0d wake_core got %0d want %0d",
                                     n_results, got.wake_core, want.wake_core));
                if (got.wake_local !== want.wake_local)
                    report($sformatf("result %0d wake_local got %0b want %0b",
                                     n_results, got.wake_local, want.wake_local));
            end
            n_results++;
        end
    end

    // ---- stimulus and end of run -------------------------------------------

    initial begin
        int         n_directed;
        int         n_random;
        int         n;
        bit         filled;
        bit         deep;
        logic [7:0] t;
        filled = 1'b0;
        deep   = 1'b0;
        lock_clear(plan_lock);
        lock_clear(model_lock);

        // directed: extremes of ids and cores, every status path but overflow
        plan(OP_LOCK,   8'h00, 3'd0, 3'd0);   // acquire free lock
        plan(OP_LOCK,   8'h00, 3'd7, 3'd7);   // recursive
        plan(OP_UNLOCK, 8'hFF, 3'd7, 3'd0);   // unlock by non-owner
        plan(OP_UNLOCK, 8'h00, 3'd0, 3'd7);   // still held
        plan(OP_LOCK,   8'hFF, 3'd7, 3'd0);   // queued
        plan(OP_LOCK,   8'h5A, 3'd3, 3'd4);   // queued
        plan(OP_LOCK,   8'hFF, 3'd7, 3'd1);   // already waiting, queued again
        plan(OP_UNLOCK, 8'h00, 3'd0, 3'd7);   // hand off, local wake
        plan(OP_UNLOCK, 8'hFF, 3'd7, 3'd0);   // hand off, remote wake
        plan(OP_UNLOCK, 8'h5A, 3'd3, 3'd3);   // hand off to second entry of 0xff
        plan(OP_LOCK,   8'h5A, 3'd5, 3'd6);   // queued behind owner
        plan(OP_UNLOCK, 8'hFF, 3'd7, 3'd5);   // hand off, local
        plan(OP_UNLOCK, 8'h5A, 3'd5, 3'd2);   // freed
        plan(OP_UNLOCK, 8'h33, 3'd2, 3'd5);   // unlock of a free lock
        plan(OP_LOCK,   8'hA5, 3'd5, 3'd2);   // acquire
        plan(OP_UNLOCK, 8'hA5, 3'd2, 3'd5);   // freed
        n_directed = pending_reqs.size();

        n_random = 0;
        while (n_random < 600) begin
            if (!filled && n_random >= 60) begin
                // fill the wait queue, overflow it, then drain by hand-offs
                filled = 1'b1;
                ensure_held();
                while (plan_lock.qcount < QCNT_FULL) begin
                    plan(OP_LOCK, other_task(plan_lock.owner_task),
                         3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
                end
                repeat (2) begin
                    plan(OP_LOCK, other_task(plan_lock.owner_task),
                         3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
                end
                release_all();
            end else if (!deep && n_random >= 120) begin
                // recurse up to the count limit, overflow, unwind
                deep = 1'b1;
                ensure_held();
                while (plan_lock.count < COUNT_MAX) begin
                    plan(OP_LOCK, plan_lock.owner_task,
                         3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
                end
                repeat (2) begin
                    plan(OP_LOCK, plan_lock.owner_task,
                         3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
                end
                while (plan_lock.count > 8'd1) begin
                    plan(OP_UNLOCK, plan_lock.owner_task,
                         3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
                end
            end else begin
                case ($urandom_range(0, 9))
                    0, 1, 2: begin
                        if (!plan_lock.owner_valid) begin
                            ensure_held();
                        end else begin
                            n = $urandom_range(1, 4);
                            repeat (n) plan(OP_LOCK, plan_lock.owner_task,
                                            3'($urandom_range(0, 7)),
                                            3'($urandom_range(0, 7)));
                            repeat (n) plan(OP_UNLOCK, plan_lock.owner_task,
                                            3'($urandom_range(0, 7)), unlock_core());
                        end
                    end
                    3, 4, 5: begin
                        ensure_held();
                        repeat ($urandom_range(1, 4)) begin
                            if (plan_lock.qcount != '0 && $urandom_range(0, 3) == 0) begin
                                // task that is already waiting asks again
                                t = plan_lock.wtask[(plan_lock.tail == '0) ?
                                        QPTR_W'(QUEUE_DEPTH - 1) : plan_lock.tail - QPTR_W'(1)];
                            end else begin
                                t = other_task(plan_lock.owner_task);
                            end
                            plan(OP_LOCK, t, 3'($urandom_range(0, 7)),
                                 3'($urandom_range(0, 7)));
                        end
                        n = plan_lock.count;
                        repeat (n) plan(OP_UNLOCK, plan_lock.owner_task,
                                        3'($urandom_range(0, 7)), unlock_core());
                    end
                    6: release_all();
                    7: plan(OP_UNLOCK, other_task(plan_lock.owner_task),
                            3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
                    default: plan(op_t'($urandom_range(0, 1)), pick_task(),
                                  3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
                endcase
            end
            n_random = pending_reqs.size() - n_directed;
        end
        n_items = pending_reqs.size();

        repeat (7) @(negedge aclk);
        aresetn = 1'b1;

        while (n_accepted < n_items || expected_results.size() != 0) begin
            @(negedge aclk);
        end
        repeat (10) @(negedge aclk);
        if (fail_count == 0) begin
            $display("recursive_mutex_fifo_handoff verification clean");
        end else begin
            $display("recursive_mutex_fifo_handoff verification failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("recursive_mutex_fifo_handoff verification failed");
        $finish;
    end

endmodule : recursive_mutex_fifo_handoff_test
`default_nettype wire
